// ----- hdl/spwm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spwm_pkg: shared definitions for the SPWM compare calculator
// Widths, register indexes and the beat types of the input, result and
// internal work queue.
// ----------------------------------------------------------------------------
package spwm_pkg;

  localparam int VOLTAGE_BITS = 16;
  localparam int PERIOD_BITS  = 16;
  localparam int MOD_BITS     = 16;
  localparam int LIMIT_W      = VOLTAGE_BITS + MOD_BITS;
  localparam int NUM_W        = VOLTAGE_BITS + 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [MOD_BITS-1:0] Q15_ONE = MOD_BITS'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_PERIOD = 2'd0,
    REG_MOD_LIMIT  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VOLTAGE_BITS-1:0] phase_a_voltage;
    logic signed [VOLTAGE_BITS-1:0] phase_b_voltage;
    logic signed [VOLTAGE_BITS-1:0] phase_c_voltage;
    logic        [VOLTAGE_BITS-1:0] dc_link_voltage;
  } in_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] compare_a;
    logic [PERIOD_BITS-1:0] compare_b;
    logic [PERIOD_BITS-1:0] compare_c;
    logic [2:0]             clamp_flags;
    logic                   zero_bus_error;
  } out_t;

  typedef struct packed {
    logic [NUM_W-1:0]        num_a;
    logic [NUM_W-1:0]        num_b;
    logic [NUM_W-1:0]        num_c;
    logic [VOLTAGE_BITS-1:0] dc_link;
    logic [2:0]              clamp;
    logic                    zero;
  } work_t;

endpackage
`default_nettype wire

// ----- hdl/spwm_compare_calc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spwm_compare_calc: three-phase sinusoidal PWM compare calculator
// Clamps three phase references to the modulation limit and scales them
// into timer compare values against the measured DC-link voltage.
// ----------------------------------------------------------------------------
// Channel   Handshake              Beat
// in_       in_push / in_full      phases A, B, C and DC-link voltage
// out_      out_pop / out_empty    compares A, B, C, clamp flags, zero bus
// cfg_      cfg_valid / cfg_ready  register index and write data
//
// A beat is registered in the front and queued; the divider lanes then work
// one period bit per cycle, and the hold state writes the result register;
// a zero bus voltage skips the division. While results are taken, the next
// queued beat loads in the same cycle as the result register is written.
// Reset empties the pipeline and the queue; no clearing pass is needed.
// A full result register stalls the divider, then the queue, then in_full.
// ----------------------------------------------------------------------------
module spwm_compare_calc import spwm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire in_t                   in_data,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic [MOD_BITS-1:0]    mlim_r, mlim_nxt;
  logic [MOD_BITS-1:0]    mlim_sat;
  logic                   q_push, q_full, q_pop, q_empty;
  work_t                  q_wdata, q_rdata;

  assign cfg_ready = 1'b1;
  assign mlim_sat  = (mlim_r > Q15_ONE) ? Q15_ONE : mlim_r;

  always_comb begin
    period_nxt = period_r;
    mlim_nxt   = mlim_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PWM_PERIOD) begin
        period_nxt = PERIOD_BITS'(cfg_data);
      end else if (cfg_index == REG_MOD_LIMIT) begin
        mlim_nxt = MOD_BITS'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      mlim_r   <= Q15_ONE;
    end else begin
      period_r <= period_nxt;
      mlim_r   <= mlim_nxt;
    end
  end

  spwm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .mod_limit (mlim_sat),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  spwm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  spwm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .period    (period_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- hdl/spwm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spwm_front: input stage and phase clamp
// Registers each input beat with its clamp limit, then clamps the three
// phases and forms the scaled numerators that are queued for division.
// ----------------------------------------------------------------------------
module spwm_front import spwm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire in_t                 in_data,
  input  wire logic [MOD_BITS-1:0] mod_limit,
  output logic                     q_push,
  output work_t                    q_data,
  input  wire logic                q_full
);

  typedef struct packed {
    logic             clamp;
    logic [NUM_W-1:0] num;
  } lane_t;

  function automatic lane_t classify(input logic [VOLTAGE_BITS-1:0] v,
                                     input logic [VOLTAGE_BITS-1:0] vdc,
                                     input logic [LIMIT_W-1:0]      lim);
    logic signed [NUM_W+1:0] wx;
    logic signed [NUM_W+1:0] limx;
    logic signed [NUM_W+1:0] nlimx;
    logic signed [NUM_W+1:0] numx;
    lane_t                   res;
    wx    = {{2{v[VOLTAGE_BITS-1]}}, v, 16'b0};
    limx  = {2'b0, lim};
    nlimx = -limx;
    res.clamp = 1'b0;
    if (wx > limx) begin
      wx        = limx;
      res.clamp = 1'b1;
    end else if (wx < nlimx) begin
      wx        = nlimx;
      res.clamp = 1'b1;
    end
    numx    = {3'b0, vdc, 15'b0} - wx;
    res.num = numx[NUM_W-1:0];
    return res;
  endfunction

  logic                 st_vld_r, st_vld_nxt;
  in_t                  st_data_r, st_data_nxt;
  logic [LIMIT_W-1:0]   st_lim_r, st_lim_nxt;
  logic                 load;
  lane_t                lane_a, lane_b, lane_c;
  logic                 zero;

  assign in_full = st_vld_r && q_full;
  assign load    = in_push && !in_full;
  assign q_push  = st_vld_r && !q_full;

  always_comb begin
    st_vld_nxt  = st_vld_r;
    st_data_nxt = st_data_r;
    st_lim_nxt  = st_lim_r;
    if (q_push) begin
      st_vld_nxt = 1'b0;
    end
    if (load) begin
      st_vld_nxt  = 1'b1;
      st_data_nxt = in_data;
      st_lim_nxt  = LIMIT_W'(mod_limit) * LIMIT_W'(in_data.dc_link_voltage);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else begin
      st_vld_r <= st_vld_nxt;
    end
    st_data_r <= st_data_nxt;
    st_lim_r  <= st_lim_nxt;
  end

  always_comb begin
    zero   = (st_data_r.dc_link_voltage == '0);
    lane_a = classify(st_data_r.phase_a_voltage, st_data_r.dc_link_voltage, st_lim_r);
    lane_b = classify(st_data_r.phase_b_voltage, st_data_r.dc_link_voltage, st_lim_r);
    lane_c = classify(st_data_r.phase_c_voltage, st_data_r.dc_link_voltage, st_lim_r);
    q_data.num_a   = lane_a.num;
    q_data.num_b   = lane_b.num;
    q_data.num_c   = lane_c.num;
    q_data.dc_link = st_data_r.dc_link_voltage;
    q_data.clamp   = zero ? 3'b000 : {lane_c.clamp, lane_b.clamp, lane_a.clamp};
    q_data.zero    = zero;
  end

endmodule
`default_nettype wire

// ----- hdl/spwm_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spwm_queue: work queue between front and back
// A short first-in first-out store of classified work beats.
// ----------------------------------------------------------------------------
module spwm_queue import spwm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire work_t wdata,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output work_t      rdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push_ok, pop_ok;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spwm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spwm_back: compare value division and result register
// Three lanes form period*num/(Vdc*65536) one period bit per cycle, each
// step adding the numerator and taking away the divisor up to twice.
// ----------------------------------------------------------------------------
module spwm_back import spwm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  wire work_t                  q_data,
  output logic                        q_pop,
  input  wire logic [PERIOD_BITS-1:0] period,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output out_t                        out_data
);

  localparam int CNT_W = $clog2(PERIOD_BITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  typedef struct packed {
    logic [NUM_W-1:0]       rem;
    logic [PERIOD_BITS-1:0] quo;
  } step_t;

  function automatic step_t div_step(input logic [NUM_W-1:0]       rem,
                                     input logic [NUM_W-1:0]       num,
                                     input logic [NUM_W-1:0]       den,
                                     input logic                   pbit,
                                     input logic [PERIOD_BITS-1:0] quo);
    logic [NUM_W+1:0] t;
    logic [NUM_W+1:0] d1;
    logic [NUM_W+1:0] d2;
    logic [NUM_W+1:0] diff;
    logic [1:0]       k;
    step_t            res;
    d1 = {2'b0, den};
    d2 = {1'b0, den, 1'b0};
    t  = {1'b0, rem, 1'b0} + (pbit ? {2'b0, num} : '0);
    if (t >= d2) begin
      diff = t - d2;
      k    = 2'd2;
    end else if (t >= d1) begin
      diff = t - d1;
      k    = 2'd1;
    end else begin
      diff = t;
      k    = 2'd0;
    end
    res.rem = diff[NUM_W-1:0];
    res.quo = {quo[PERIOD_BITS-2:0], 1'b0} + PERIOD_BITS'(k);
    return res;
  endfunction

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [NUM_W-1:0]       den_r, den_nxt;
  logic [NUM_W-1:0]       num_r [3];
  logic [NUM_W-1:0]       num_nxt [3];
  logic [NUM_W-1:0]       rem_r [3];
  logic [NUM_W-1:0]       rem_nxt [3];
  logic [PERIOD_BITS-1:0] quo_r [3];
  logic [PERIOD_BITS-1:0] quo_nxt [3];
  logic [2:0]             flags_r, flags_nxt;
  logic                   zero_r, zero_nxt;
  logic                   out_vld_r, out_vld_nxt;
  out_t                   out_data_r, out_data_nxt;
  logic                   out_free, out_wr, load;
  step_t                  st [3];

  assign out_free  = !out_vld_r || out_pop;
  assign out_wr    = (state_r == ST_HOLD) && out_free;
  assign load      = ((state_r == ST_IDLE) || out_wr) && !q_empty;
  assign q_pop     = load;
  assign out_empty = !out_vld_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      st[i] = div_step(rem_r[i], num_r[i], den_r, period[cnt_r], quo_r[i]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    den_nxt   = den_r;
    flags_nxt = flags_r;
    zero_nxt  = zero_r;
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = num_r[i];
      rem_nxt[i] = rem_r[i];
      quo_nxt[i] = quo_r[i];
    end
    case (state_r)
      ST_IDLE: begin
      end
      ST_RUN: begin
        for (int i = 0; i < 3; i++) begin
          rem_nxt[i] = st[i].rem;
          quo_nxt[i] = st[i].quo;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load) begin
      state_nxt  = q_data.zero ? ST_HOLD : ST_RUN;
      cnt_nxt    = CNT_W'(PERIOD_BITS - 1);
      den_nxt    = {q_data.dc_link, 16'b0};
      num_nxt[0] = q_data.num_a;
      num_nxt[1] = q_data.num_b;
      num_nxt[2] = q_data.num_c;
      flags_nxt  = q_data.clamp;
      zero_nxt   = q_data.zero;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = '0;
        quo_nxt[i] = q_data.zero ? (period >> 1) : '0;
      end
    end
  end

  always_comb begin
    out_vld_nxt  = out_vld_r && !out_pop;
    out_data_nxt = out_data_r;
    if (out_wr) begin
      out_vld_nxt                 = 1'b1;
      out_data_nxt.compare_a      = quo_r[0];
      out_data_nxt.compare_b      = quo_r[1];
      out_data_nxt.compare_c      = quo_r[2];
      out_data_nxt.clamp_flags    = flags_r;
      out_data_nxt.zero_bus_error = zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cnt_r      <= cnt_nxt;
    den_r      <= den_nxt;
    flags_r    <= flags_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= num_nxt[i];
      rem_r[i] <= rem_nxt[i];
      quo_r[i] <= quo_nxt[i];
    end
  end

endmodule
`default_nettype wire

// ----- tb/spwm_compare_calc_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_compare_calc_test: self-checking bench for the SPWM compare calculator
// A short table of directed beats, including zero bus voltage, the voltage
// and register extremes and the saturating modulation limit, is followed by
// random beats over several register settings and idle and stall phases. Every
// result is checked field by field, against the table's values for typed
// rows and otherwise against a predictor of the clamp and compare arithmetic.
// ----------------------------------------------------------------------------
module spwm_compare_calc_test;
  import spwm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CHUNK_BEATS = 45;
  localparam int N_ROWS = 21;

  typedef struct packed {
    logic       is_cfg;
    logic [15:0] period;
    logic [15:0] limit;
    in_t        item;
    logic       typed;
    out_t       want;
  } stim_row_t;

  localparam in_t  NO_ITEM   = '0;
  localparam out_t NO_RESULT = '0;

  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{1'b0, 16'd0, 16'd0, '{16'sd1234, -16'sd5, 16'sd32767, 16'd500},
      1'b1, '{16'd0, 16'd0, 16'd0, 3'b101, 1'b0}},
    '{1'b0, 16'd0, 16'd0, '{16'sd77, -16'sd77, 16'sd0, 16'd0},
      1'b1, '{16'd0, 16'd0, 16'd0, 3'b000, 1'b1}},
    '{1'b1, 16'd1000, 16'd32768, NO_ITEM, 1'b0, NO_RESULT},
    '{1'b0, 16'd0, 16'd0, '{16'sd0, 16'sd0, 16'sd0, 16'd1000},
      1'b1, '{16'd500, 16'd500, 16'd500, 3'b000, 1'b0}},
    '{1'b0, 16'd0, 16'd0, '{16'sd1000, -16'sd1000, 16'sd0, 16'd2000},
      1'b1, '{16'd0, 16'd1000, 16'd500, 3'b000, 1'b0}},
    '{1'b0, 16'd0, 16'd0, '{16'sd32767, -16'sd32768, 16'sd50, 16'd100},
      1'b1, '{16'd0, 16'd1000, 16'd0, 3'b011, 1'b0}},
    '{1'b0, 16'd0, 16'd0, '{-16'sd32768, 16'sd32767, 16'sd0, 16'd0},
      1'b1, '{16'd500, 16'd500, 16'd500, 3'b000, 1'b1}},
    '{1'b0, 16'd0, 16'd0, '{16'sd32767, -16'sd32768, -16'sd1, 16'd65535},
      1'b0, NO_RESULT},
    '{1'b0, 16'd0, 16'd0, '{16'h5555, 16'hAAAA, 16'h7FFF, 16'hFFFF}, 1'b0, NO_RESULT},
    '{1'b0, 16'd0, 16'd0, '{16'sd1, -16'sd1, 16'sd0, 16'd1}, 1'b0, NO_RESULT},
    '{1'b1, 16'd65535, 16'd65535, NO_ITEM, 1'b0, NO_RESULT},
    '{1'b0, 16'd0, 16'd0, '{-16'sd32768, 16'sd32767, 16'sd0, 16'd65535},
      1'b0, NO_RESULT},
    '{1'b0, 16'd0, 16'd0, '{16'sd32767, -16'sd32768, 16'sd12345, 16'd1},
      1'b0, NO_RESULT},
    '{1'b0, 16'd0, 16'd0, '{16'sd300, -16'sd300, 16'sd0, 16'd0},
      1'b1, '{16'd32767, 16'd32767, 16'd32767, 3'b000, 1'b1}},
    '{1'b0, 16'd0, 16'd0, '{16'hAAAA, 16'h5555, 16'sd8000, 16'd40000},
      1'b0, NO_RESULT},
    '{1'b1, 16'd65535, 16'd0, NO_ITEM, 1'b0, NO_RESULT},
    '{1'b0, 16'd0, 16'd0, '{16'sd1, -16'sd1, 16'sd0, 16'd300},
      1'b1, '{16'd32767, 16'd32767, 16'd32767, 3'b011, 1'b0}},
    '{1'b0, 16'd0, 16'd0, '{16'sd32767, -16'sd32768, -16'sd7, 16'd65535},
      1'b0, NO_RESULT},
    '{1'b1, 16'd1, 16'd16384, NO_ITEM, 1'b0, NO_RESULT},
    '{1'b0, 16'd0, 16'd0, '{16'sd100, -16'sd100, 16'sd0, 16'd200}, 1'b0, NO_RESULT},
    '{1'b0, 16'd0, 16'd0, '{-16'sd32768, 16'sd32767, -16'sd1, 16'd65534},
      1'b0, NO_RESULT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  in_t                   in_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [15:0] period_reg = 16'd0;
  logic [15:0] limit_reg  = Q15_ONE;
  out_t        pending_compares [$];
  out_t        oldest;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  spwm_compare_calc dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint effective_limit();
    return (limit_reg > Q15_ONE) ? longint'(Q15_ONE) : longint'(limit_reg);
  endfunction

  function automatic out_t predict_compares(input in_t beat);
    out_t        r;
    longint      vdc, bound, w, num, den;
    logic [15:0] phases [3];
    logic [15:0] cmp [3];
    int          i;
    r = '0;
    vdc = longint'(beat.dc_link_voltage);
    phases[0] = beat.phase_a_voltage;
    phases[1] = beat.phase_b_voltage;
    phases[2] = beat.phase_c_voltage;
    if (vdc == 0) begin
      for (i = 0; i < 3; i++) cmp[i] = period_reg >> 1;
      r.zero_bus_error = 1'b1;
    end else begin
      bound = effective_limit() * vdc;
      for (i = 0; i < 3; i++) begin
        w = longint'($signed(phases[i])) * 65536;
        if (w > bound) begin
          w = bound;
          r.clamp_flags[i] = 1'b1;
        end else if (w < -bound) begin
          w = -bound;
          r.clamp_flags[i] = 1'b1;
        end
        num = vdc * 32768 - w;
        den = vdc * 65536;
        cmp[i] = 16'((longint'(period_reg) * num) / den);
      end
    end
    r.compare_a = cmp[0];
    r.compare_b = cmp[1];
    r.compare_c = cmp[2];
    return r;
  endfunction

  function automatic in_t random_item();
    in_t    it;
    longint vdc, bound;
    int     val, i;
    logic [15:0] v [3];
    case ($urandom_range(19))
      0:       vdc = 0;
      1, 2, 3: vdc = longint'($urandom_range(64, 1));
      4:       vdc = 65535;
      default: vdc = longint'($urandom_range(65535, 1));
    endcase
    bound = (effective_limit() * vdc) / 65536;
    for (i = 0; i < 3; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: val = int'($urandom_range(int'(vdc))) - int'(vdc / 2);
        6, 7: val = ($urandom_range(1) ? int'(bound) : -int'(bound))
                    + int'($urandom_range(2)) - 1;
        default: val = int'($urandom_range(65535));
      endcase
      v[i] = 16'(val);
    end
    it.phase_a_voltage = v[0];
    it.phase_b_voltage = v[1];
    it.phase_c_voltage = v[2];
    it.dc_link_voltage = 16'(vdc);
    return it;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Results are taken at the rising edge and compared in arrival order.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_compares.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, out_data);
        mismatch_count++;
      end else begin
        oldest = pending_compares.pop_front();
        check_field("compare_a", oldest.compare_a, out_data.compare_a);
        check_field("compare_b", oldest.compare_b, out_data.compare_b);
        check_field("compare_c", oldest.compare_c, out_data.compare_c);
        check_field("clamp_flags", 16'(oldest.clamp_flags), 16'(out_data.clamp_flags));
        check_field("zero_bus_error", 16'(oldest.zero_bus_error),
                    16'(out_data.zero_bus_error));
      end
    end
  end

  always @(negedge clk) out_pop <= ($urandom_range(99) >= stall_pct);

  task automatic send_item(input in_t beat, input logic typed, input out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_full !== 1'b0);
    pending_compares.push_back(typed ? want : predict_compares(beat));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_push <= 1'b0;
    do @(negedge clk); while (pending_compares.size() != 0);
  endtask

  task automatic apply_settings(input logic [15:0] period, input logic [15:0] limit);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] dat [3];
    int                    k;
    idx[0] = REG_PWM_PERIOD;
    dat[0] = period;
    idx[1] = REG_MOD_LIMIT;
    dat[1] = limit;
    idx[2] = REG_SPARE;
    dat[2] = CFG_DATA_W'($urandom_range(65535));
    for (k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      if (idx[k] == REG_PWM_PERIOD) period_reg = dat[k];
      else if (idx[k] == REG_MOD_LIMIT) limit_reg = dat[k];
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          r, ph, chunk, n;
    logic [15:0] period, limit;
    int          idle_by_phase [4];
    int          stall_by_phase [4];
    idle_by_phase  = '{0, 75, 0, 20};
    stall_by_phase = '{0, 0, 75, 20};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    for (r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].is_cfg) begin
        wait_drain();
        apply_settings(DIRECTED[r].period, DIRECTED[r].limit);
      end else begin
        send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      for (chunk = 0; chunk < 3; chunk++) begin
        wait_drain();
        case ($urandom_range(5))
          0:       period = 16'd0;
          1:       period = 16'hFFFF;
          2:       period = 16'd1;
          default: period = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(5))
          0:       limit = 16'd0;
          1:       limit = Q15_ONE;
          2:       limit = 16'hFFFF;
          default: limit = 16'($urandom_range(65535));
        endcase
        apply_settings(period, limit);
        for (n = 0; n < CHUNK_BEATS; n++) send_item(random_item(), 1'b0, NO_RESULT);
      end
    end
    wait_drain();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("spwm_compare_calc_test: clean");
    end else begin
      $display("spwm_compare_calc_test: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timed out with %0d results outstanding", $time,
             pending_compares.size());
    $display("spwm_compare_calc_test: errors");
    $finish;
  end

endmodule
